FILE: src/touch_coordinate_mapper_core_defines.svh
// Assertion macros used by the checker file.
`ifndef TOUCH_COORDINATE_MAPPER_CORE_DEFINES_SVH
`define TOUCH_COORDINATE_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tcm_pkg.sv
`timescale 1ns / 1ps

package tcm_pkg;

  localparam int RAW_W     = 12;
  localparam int COEF_W    = 32;
  localparam int COORD_W   = 10;
  localparam int PRESS_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int ROT_W     = 2;
  localparam int OUTC_W    = 2;

  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 320;

  // signed coef times zero-extended raw value
  localparam int PROD_W  = COEF_W + RAW_W + 1;
  localparam int ACC_W   = PROD_W + 3;
  localparam int Q_SHIFT = 16;
  localparam int Q_W     = ACC_W - Q_SHIFT;
  localparam logic [ACC_W-1:0] Q_HALF = ACC_W'(32'h8000);

  localparam logic [PRESS_W-1:0] FULL_SCALE        = PRESS_W'(4095);
  localparam logic [PRESS_W-1:0] DEFAULT_THRESHOLD = PRESS_W'(350);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN_RAW_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN_RAW_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN_RAW_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN_RAW_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH = 3'd7;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTCOME_TOUCH     = 2'd0;
  localparam logic [OUTC_W-1:0] OUTCOME_LOW       = 2'd1;
  localparam logic [OUTC_W-1:0] OUTCOME_OFF_PANEL = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] x_gain_raw_x;
    logic signed [COEF_W-1:0] x_gain_raw_y;
    logic signed [COEF_W-1:0] x_offset;
    logic signed [COEF_W-1:0] y_gain_raw_x;
    logic signed [COEF_W-1:0] y_gain_raw_y;
    logic signed [COEF_W-1:0] y_offset;
    logic [ROT_W-1:0]         rotation;
    logic [PRESS_W-1:0]       pressure_threshold;
  } cfg_t;

  // coefficients and rotation zero, threshold at its default (lowest field)
  localparam cfg_t CFG_RESET = cfg_t'({(6*COEF_W + ROT_W)'(0), DEFAULT_THRESHOLD});

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] z_first;
    logic [RAW_W-1:0] z_second;
  } sample_t;

  typedef struct packed {
    logic [PRESS_W-1:0]       pressure;
    logic                     low;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] yx;
    logic signed [PROD_W-1:0] yy;
  } mid_t;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] disp_x;
    logic [COORD_W-1:0] disp_y;
    logic [PRESS_W-1:0] pressure;
    logic [OUTC_W-1:0]  outcome;
  } result_t;

endpackage

FILE: src/touch_coordinate_mapper_core.sv
`timescale 1ns / 1ps
// Pipeline: an accepted item passes through the input register, the product
//   register and the result register before it shows on the output.
// Throughput: one item per cycle while the output is not stalled; the three stages hand on under a ready chain.
// Reset: asynchronous, active low; clears stage valids and the calibration
//   registers (coefficients 0, rotation 0, pressure threshold 350).

module touch_coordinate_mapper_core #(
  parameter int PANEL_WIDTH  = tcm_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tcm_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcm_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tcm_pkg::RAW_W-1:0]       raw_x_i,
  input  logic [tcm_pkg::RAW_W-1:0]       raw_y_i,
  input  logic [tcm_pkg::RAW_W-1:0]       z_first_i,
  input  logic [tcm_pkg::RAW_W-1:0]       z_second_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            touched_o,
  output logic [tcm_pkg::COORD_W-1:0]     disp_x_o,
  output logic [tcm_pkg::COORD_W-1:0]     disp_y_o,
  output logic [tcm_pkg::PRESS_W-1:0]     pressure_o,
  output logic [tcm_pkg::OUTC_W-1:0]      outcome_o
);

  // ---------------------------------------------------------------------------
  // Calibration registers. Written only while the pipe is empty, so the stages read
  // them live; the user is bound to this, the block itself does not enforce it.
  // ---------------------------------------------------------------------------
  tcm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcm_pkg::REG_X_GAIN_RAW_X: cfg_d.x_gain_raw_x = signed'(cfg_data_i);
        tcm_pkg::REG_X_GAIN_RAW_Y: cfg_d.x_gain_raw_y = signed'(cfg_data_i);
        tcm_pkg::REG_X_OFFSET:     cfg_d.x_offset     = signed'(cfg_data_i);
        tcm_pkg::REG_Y_GAIN_RAW_X: cfg_d.y_gain_raw_x = signed'(cfg_data_i);
        tcm_pkg::REG_Y_GAIN_RAW_Y: cfg_d.y_gain_raw_y = signed'(cfg_data_i);
        tcm_pkg::REG_Y_OFFSET:     cfg_d.y_offset     = signed'(cfg_data_i);
        tcm_pkg::REG_ROTATION:
          cfg_d.rotation = cfg_data_i[tcm_pkg::ROT_W-1:0];
        tcm_pkg::REG_PRESS_THRESH:
          cfg_d.pressure_threshold = cfg_data_i[tcm_pkg::PRESS_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tcm_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage takes a new item when it is empty or its
  // successor takes the one it holds, so a stalled output does not stop the
  // input until all three registers are full.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_rdy, s2_rdy, s1_rdy;

  assign out_rdy = !out_valid_q || !out_stall_i;
  assign s2_rdy  = !s2_valid_q || out_rdy;
  assign s1_rdy  = !s1_valid_q || s2_rdy;

  assign s1_valid_d  = s1_rdy  ? in_valid_i : s1_valid_q;
  assign s2_valid_d  = s2_rdy  ? s1_valid_q : s2_valid_q;
  assign out_valid_d = out_rdy ? s2_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !s1_rdy;
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Datapath: input register -> pressure + products -> product register ->
  // sum/round/bounds/rotate -> result register.
  // ---------------------------------------------------------------------------
  tcm_pkg::sample_t smp_q, smp_d;
  tcm_pkg::mid_t    mid_q, mid_d;
  tcm_pkg::result_t res_q, res_d;

  assign smp_d.raw_x    = raw_x_i;
  assign smp_d.raw_y    = raw_y_i;
  assign smp_d.z_first  = z_first_i;
  assign smp_d.z_second = z_second_i;

  tcm_front u_front (
    .smp_i (smp_q),
    .cfg_i (cfg_q),
    .mid_o (mid_d)
  );

  tcm_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .mid_i (mid_q),
    .cfg_i (cfg_q),
    .res_o (res_d)
  );

  // payload registers, no reset; they only load alongside a valid item
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      smp_q <= smp_d;
    end
    if (s2_rdy && s1_valid_q) begin
      mid_q <= mid_d;
    end
    if (out_rdy && s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign touched_o  = res_q.touched;
  assign disp_x_o   = res_q.disp_x;
  assign disp_y_o   = res_q.disp_y;
  assign pressure_o = res_q.pressure;
  assign outcome_o  = res_q.outcome;

endmodule

FILE: src/tcm_front.sv
`timescale 1ns / 1ps

// Pressure, threshold test and the four gain products.
module tcm_front (
  input  tcm_pkg::sample_t smp_i,
  input  tcm_pkg::cfg_t    cfg_i,
  output tcm_pkg::mid_t    mid_o
);

  logic [tcm_pkg::PRESS_W-1:0] pressure;
  logic [tcm_pkg::PRESS_W-1:0] thr;
  logic [tcm_pkg::RAW_W-1:0]   z_diff;
  logic signed [tcm_pkg::RAW_W:0] rx_s;
  logic signed [tcm_pkg::RAW_W:0] ry_s;

  // 4095 + z1 - z2 saturates at full scale whenever z1 > z2 and can't go negative; equal z1 and z2 give zero
  always_comb begin
    z_diff = smp_i.z_second - smp_i.z_first;
    if (smp_i.z_first == smp_i.z_second) begin
      pressure = '0;
    end else if (smp_i.z_first > smp_i.z_second) begin
      pressure = tcm_pkg::FULL_SCALE;
    end else begin
      pressure = tcm_pkg::FULL_SCALE - z_diff;
    end
  end

  assign thr = (cfg_i.pressure_threshold == '0) ? tcm_pkg::DEFAULT_THRESHOLD
                                                 : cfg_i.pressure_threshold;

  assign rx_s = signed'({1'b0, smp_i.raw_x});
  assign ry_s = signed'({1'b0, smp_i.raw_y});

  assign mid_o.pressure = pressure;
  assign mid_o.low      = (pressure <= thr);
  assign mid_o.xx       = tcm_pkg::PROD_W'(cfg_i.x_gain_raw_x * rx_s);
  assign mid_o.xy       = tcm_pkg::PROD_W'(cfg_i.x_gain_raw_y * ry_s);
  assign mid_o.yx       = tcm_pkg::PROD_W'(cfg_i.y_gain_raw_x * rx_s);
  assign mid_o.yy       = tcm_pkg::PROD_W'(cfg_i.y_gain_raw_y * ry_s);

endmodule

FILE: src/tcm_back.sv
`timescale 1ns / 1ps

// Affine sum, symmetric rounding, panel bounds and rotation.
module tcm_back #(
  parameter int PANEL_WIDTH  = tcm_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tcm_pkg::PANEL_HEIGHT_DEF
) (
  input  tcm_pkg::mid_t    mid_i,
  input  tcm_pkg::cfg_t    cfg_i,
  output tcm_pkg::result_t res_o
);

  localparam int ACC_W = tcm_pkg::ACC_W;
  localparam int Q_W   = tcm_pkg::Q_W;
  localparam int PW    = tcm_pkg::PROD_W;
  localparam int CW    = tcm_pkg::COEF_W;
  localparam logic [Q_W-1:0] W_LIM = Q_W'(PANEL_WIDTH);
  localparam logic [Q_W-1:0] H_LIM = Q_W'(PANEL_HEIGHT);
  localparam logic [tcm_pkg::COORD_W-1:0] W_MAX = tcm_pkg::COORD_W'(PANEL_WIDTH - 1);
  localparam logic [tcm_pkg::COORD_W-1:0] H_MAX = tcm_pkg::COORD_W'(PANEL_HEIGHT - 1);

  // returns {negative, rounded magnitude}
  function automatic logic [Q_W:0] round_q(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    sum = mag + tcm_pkg::Q_HALF;
    return {acc[ACC_W-1], sum[ACC_W-1:tcm_pkg::Q_SHIFT]};
  endfunction

  logic [ACC_W-1:0] acc_x;
  logic [ACC_W-1:0] acc_y;
  logic [Q_W:0]     rnd_x;
  logic [Q_W:0]     rnd_y;
  logic             off_panel;
  logic [tcm_pkg::COORD_W-1:0] bx;
  logic [tcm_pkg::COORD_W-1:0] by;
  logic [tcm_pkg::COORD_W-1:0] lx;
  logic [tcm_pkg::COORD_W-1:0] ly;

  assign acc_x = {{(ACC_W-PW){mid_i.xx[PW-1]}}, mid_i.xx}
               + {{(ACC_W-PW){mid_i.xy[PW-1]}}, mid_i.xy}
               + {{(ACC_W-CW){cfg_i.x_offset[CW-1]}}, cfg_i.x_offset};
  assign acc_y = {{(ACC_W-PW){mid_i.yx[PW-1]}}, mid_i.yx}
               + {{(ACC_W-PW){mid_i.yy[PW-1]}}, mid_i.yy}
               + {{(ACC_W-CW){cfg_i.y_offset[CW-1]}}, cfg_i.y_offset};

  assign rnd_x = round_q(acc_x);
  assign rnd_y = round_q(acc_y);

  // a negative value that rounds to zero is still on the panel
  assign off_panel = (rnd_x[Q_W] && (rnd_x[Q_W-1:0] != '0))
                  || (rnd_y[Q_W] && (rnd_y[Q_W-1:0] != '0))
                  || (!rnd_x[Q_W] && (rnd_x[Q_W-1:0] >= W_LIM))
                  || (!rnd_y[Q_W] && (rnd_y[Q_W-1:0] >= H_LIM));

  assign bx = rnd_x[tcm_pkg::COORD_W-1:0];
  assign by = rnd_y[tcm_pkg::COORD_W-1:0];

  always_comb begin
    case (cfg_i.rotation)
      tcm_pkg::ROT_90: begin
        lx = by;
        ly = W_MAX - bx;
      end
      tcm_pkg::ROT_180: begin
        lx = W_MAX - bx;
        ly = H_MAX - by;
      end
      tcm_pkg::ROT_270: begin
        lx = H_MAX - by;
        ly = bx;
      end
      default: begin
        lx = bx;
        ly = by;
      end
    endcase
  end

  always_comb begin
    res_o.pressure = mid_i.pressure;
    res_o.touched  = 1'b0;
    res_o.disp_x   = '0;
    res_o.disp_y   = '0;
    if (mid_i.low) begin
      res_o.outcome = tcm_pkg::OUTCOME_LOW;
    end else if (off_panel) begin
      res_o.outcome = tcm_pkg::OUTCOME_OFF_PANEL;
    end else begin
      res_o.outcome = tcm_pkg::OUTCOME_TOUCH;
      res_o.touched = 1'b1;
      res_o.disp_x  = lx;
      res_o.disp_y  = ly;
    end
  end

endmodule

FILE: src/tcm_checker.sv
`timescale 1ns / 1ps
`include "touch_coordinate_mapper_core_defines.svh"

module tcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          touched_o,
  input logic [tcm_pkg::COORD_W-1:0]   disp_x_o,
  input logic [tcm_pkg::COORD_W-1:0]   disp_y_o,
  input logic [tcm_pkg::PRESS_W-1:0]   pressure_o,
  input logic [tcm_pkg::OUTC_W-1:0]    outcome_o
);

  logic code_ok;
  logic no_touch;
  logic coord_zero;
  logic zero_press;
  logic is_low;
  logic out_hold;
  logic [tcm_pkg::COORD_W*2+tcm_pkg::PRESS_W+tcm_pkg::OUTC_W:0] res_w;

  assign code_ok    = (touched_o == (outcome_o == tcm_pkg::OUTCOME_TOUCH))
                   && (outcome_o <= tcm_pkg::OUTCOME_OFF_PANEL);
  assign no_touch   = out_valid_o && !touched_o;
  assign coord_zero = (disp_x_o == '0) && (disp_y_o == '0);
  assign zero_press = out_valid_o && (pressure_o == '0);
  assign is_low     = (outcome_o == tcm_pkg::OUTCOME_LOW);
  assign out_hold   = out_valid_o && out_stall_i;
  assign res_w      = {out_valid_o, disp_x_o, disp_y_o, pressure_o, outcome_o};

  // touched flag and outcome code must agree
  `TCM_ASSERT_SAME(a_touch_code, clk_i, rst_ni, out_valid_o, code_ok, "touched/outcome mismatch")

  // coordinates are zero unless a touch was reported
  `TCM_ASSERT_SAME(a_zero_coord, clk_i, rst_ni, no_touch, coord_zero, "coords without touch")

  // zero pressure can never clear any threshold
  `TCM_ASSERT_SAME(a_zero_press, clk_i, rst_ni, zero_press, is_low, "zero pressure not flagged low")

  // a stalled result stays put
  `TCM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_hold, $stable(res_w), "held result changed")

endmodule

bind touch_coordinate_mapper_core tcm_checker u_tcm_checker (.*);
